>>> hdl/gld_pkg.sv
package gld_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_PULL    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PIXEL     = 3'd0,
      ST_NEED_DATA = 3'd1,
      ST_END       = 3'd2,
      ST_ERROR     = 3'd3,
      ST_ACCEPTED  = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FIN_RUN   = 2'd0,
      FIN_END   = 2'd1,
      FIN_ERROR = 2'd2
   } finish_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FETCH,
      S_CODE,
      S_WALK,
      S_WALK_RD,
      S_POP
   } fsm_type;

endpackage

>>> hdl/gif_lzw_decoder_core.sv
// GIF LZW decoder core.
// Request channel: drive req_cmd and req_data_byte with start high; a beat is
// taken at a rising edge where start is high and busy is low. busy rises the
// cycle after a push or pull beat and stays high until its response is issued.
// Command push queues one raw stream byte (count bytes included) into the
// byte FIFO and answers accepted or fifo full from S_DECIDE.
// Command pull returns one pixel index, or need_data, end or error.
// Command restart reloads the decoder from csr_min_code_size, keeps the
// FIFO contents and answers nothing.
// Response channel: rsp_strobe marks a single cycle with rsp_status and
// rsp_pixel; the receiver must take it then, there is no back pressure.
// Sequence: a pull with pixels on the stack passes S_DECIDE and S_POP. A pull
// that must decode passes S_DECIDE and S_FETCH per FIFO byte consumed, S_DECIDE
// and S_CODE per clear or end code, S_DECIDE, S_CODE and S_WALK per other code,
// S_WALK_RD and S_WALK per dictionary entry walked (one prefix/suffix memory
// read each), then S_DECIDE and S_POP. A new pull is not taken until the
// response to the last one has been issued.
// csr channel: write csr_min_code_size only while busy is low and idle.
// Reset: synchronous, clears the FIFO, the reservoir and the stack; the
// dictionary and stack memories are not cleared and need no clearing pass.
module gif_lzw_decoder_core
   import gld_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12,
   parameter int FIFO_DEPTH    = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   output logic       rsp_strobe,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_pixel,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_min_code_size
);

   localparam int TS = 1 << MAX_CODE_BITS;
   localparam int FAW = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FCW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = FCW + 1;
   localparam int CW = MAX_CODE_BITS;
   localparam int NW = MAX_CODE_BITS + 1;

   logic [7:0] fifo_mem [FIFO_DEPTH];
   logic [CW-1:0] prefix_mem [TS];
   logic [7:0] suffix_mem [TS];
   logic [7:0] stack_mem [TS];

   fsm_type state_ff, state_in;
   logic [3:0] size_cfg_ff;
   logic [FAW-1:0] head_ff, head_in;
   logic [FCW-1:0] fill_ff, fill_in;
   logic [23:0] res_ff, res_in;
   logic [4:0] rbits_ff, rbits_in;
   logic [7:0] left_ff, left_in;
   logic [3:0] asize_ff, asize_in;
   logic [3:0] cwid_ff, cwid_in;
   logic [NW-1:0] nfree_ff, nfree_in;
   logic [NW-1:0] wlim_ff, wlim_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic pvalid_ff, pvalid_in;
   logic [7:0] first_ff, first_in;
   logic [NW-1:0] sdep_ff, sdep_in;
   finish_type fin_ff, fin_in;
   logic [CW-1:0] code_ff, code_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [1:0] cmd_ff;
   logic [7:0] byte_ff;
   logic strobe_ff, strobe_in;
   logic [2:0] status_ff, status_in;
   logic [7:0] pixel_ff, pixel_in;

   logic [7:0] fifo_rd_ff;
   logic [CW-1:0] prefix_rd_ff;
   logic [7:0] suffix_rd_ff;
   logic [7:0] stack_rd_ff;

   logic fifo_we, tab_we, stk_we, fifo_re;
   logic [FAW-1:0] fifo_wa;
   logic [CW-1:0] tab_wa, tab_ra, stk_wa, stk_ra;
   logic [CW-1:0] tab_wp;
   logic [7:0] tab_ws, stk_wd;

   logic [NW-1:0] clr;
   logic [4:0] csz;

   function automatic logic [FAW-1:0] fifo_next(input logic [FAW-1:0] p);
      logic [FAW-1:0] r;
      if (32'(p) == FIFO_DEPTH - 1) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   assign clr = NW'(1) << asize_ff;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_pixel = pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) size_cfg_ff <= 4'd8;
      else if (csr_valid && csr_ready) size_cfg_ff <= csr_min_code_size;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[fifo_wa] <= byte_ff;
      if (fifo_re) fifo_rd_ff <= fifo_mem[head_ff];
      if (tab_we) begin
         prefix_mem[tab_wa] <= tab_wp;
         suffix_mem[tab_wa] <= tab_ws;
      end
      prefix_rd_ff <= prefix_mem[tab_ra];
      suffix_rd_ff <= suffix_mem[tab_ra];
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      stack_rd_ff <= stack_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      cur_ff  <= cur_in;
      pixel_ff <= pixel_in;
      status_ff <= status_in;
      if (start && !busy) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         fill_ff <= '0;
         res_ff <= '0;
         rbits_ff <= '0;
         left_ff <= '0;
         asize_ff <= 4'd8;
         cwid_ff <= 4'd9;
         nfree_ff <= NW'(258);
         wlim_ff <= NW'(512);
         prev_ff <= '0;
         pvalid_ff <= 1'b0;
         first_ff <= '0;
         sdep_ff <= '0;
         fin_ff <= (MAX_CODE_BITS > 8) ? FIN_RUN : FIN_ERROR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         res_ff <= res_in;
         rbits_ff <= rbits_in;
         left_ff <= left_in;
         asize_ff <= asize_in;
         cwid_ff <= cwid_in;
         nfree_ff <= nfree_in;
         wlim_ff <= wlim_in;
         prev_ff <= prev_in;
         pvalid_ff <= pvalid_in;
         first_ff <= first_in;
         sdep_ff <= sdep_in;
         fin_ff <= fin_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      logic [23:0] mask;
      logic [CW-1:0] c;
      logic [NW-1:0] ext;
      logic [SW-1:0] wsum;
      logic bad;
      state_in = state_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      res_in = res_ff;
      rbits_in = rbits_ff;
      left_in = left_ff;
      asize_in = asize_ff;
      cwid_in = cwid_ff;
      nfree_in = nfree_ff;
      wlim_in = wlim_ff;
      prev_in = prev_ff;
      pvalid_in = pvalid_ff;
      first_in = first_ff;
      sdep_in = sdep_ff;
      fin_in = fin_ff;
      code_in = code_ff;
      cur_in = cur_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      pixel_in = pixel_ff;
      fifo_we = 1'b0;
      fifo_re = 1'b0;
      fifo_wa = fifo_next(head_ff);
      tab_we = 1'b0;
      tab_wa = nfree_ff[CW-1:0];
      tab_wp = prev_ff;
      tab_ws = cur_ff[7:0];
      tab_ra = cur_ff;
      stk_we = 1'b0;
      stk_wa = sdep_ff[CW-1:0];
      stk_wd = suffix_rd_ff;
      stk_ra = sdep_ff[CW-1:0] - 1'b1;
      mask = (24'd1 << cwid_ff) - 24'd1;
      c = CW'(res_ff & mask);
      ext = NW'(c);
      wsum = SW'(head_ff) + SW'(fill_ff);
      bad = 1'b0;
      csz = {1'b0, size_cfg_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_cmd) inside
                  CMD_PUSH, CMD_PULL: state_in = S_DECIDE;
                  CMD_RESTART: begin
                     if (csz < 5'd1 || csz > 5'd8 || 32'(csz) >= MAX_CODE_BITS) begin
                        fin_in = FIN_ERROR;
                        asize_in = 4'd1;
                     end else begin
                        fin_in = FIN_RUN;
                        asize_in = size_cfg_ff;
                     end
                     cwid_in = asize_in + 4'd1;
                     nfree_in = (NW'(1) << asize_in) + NW'(2);
                     wlim_in = NW'(1) << cwid_in;
                     prev_in = '0;
                     pvalid_in = 1'b0;
                     first_in = '0;
                     res_in = '0;
                     rbits_in = '0;
                     left_in = '0;
                     sdep_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_DECIDE: begin
            pixel_in = '0;
            if (cmd_ff == CMD_PUSH) begin
               strobe_in = 1'b1;
               state_in = S_IDLE;
               if (32'(fill_ff) < FIFO_DEPTH) begin
                  fifo_we = 1'b1;
                  if (32'(wsum) >= FIFO_DEPTH) wsum = wsum - SW'(FIFO_DEPTH);
                  fifo_wa = FAW'(wsum);
                  fill_in = fill_ff + 1'b1;
                  status_in = ST_ACCEPTED;
               end else status_in = ST_FULL;
            end else if (fin_ff == FIN_END) begin
               strobe_in = 1'b1; status_in = ST_END; state_in = S_IDLE;
            end else if (fin_ff == FIN_ERROR) begin
               strobe_in = 1'b1; status_in = ST_ERROR; state_in = S_IDLE;
            end else if (sdep_ff != '0) begin
               sdep_in = sdep_ff - 1'b1;
               state_in = S_POP;
            end else if ({1'b0, rbits_ff} >= {1'b0, cwid_ff}) begin
               state_in = S_CODE;
            end else if (fill_ff == '0) begin
               strobe_in = 1'b1; status_in = ST_NEED_DATA; state_in = S_IDLE;
            end else begin
               fifo_re = 1'b1;
               head_in = fifo_next(head_ff);
               fill_in = fill_ff - 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_DECIDE;
            if (left_ff == '0) begin
               if (fifo_rd_ff == '0) fin_in = FIN_END;
               else left_in = fifo_rd_ff;
            end else begin
               res_in = res_ff | (24'(fifo_rd_ff) << rbits_ff);
               rbits_in = rbits_ff + 5'd8;
               left_in = left_ff - 1'b1;
            end
         end
         S_CODE: begin
            res_in = res_ff >> cwid_ff;
            rbits_in = rbits_ff - {1'b0, cwid_ff};
            state_in = S_DECIDE;
            code_in = c;
            cur_in = c;
            if (ext == clr + NW'(1)) fin_in = FIN_END;
            else if (ext == clr) begin
               cwid_in = asize_ff + 4'd1;
               nfree_in = clr + NW'(2);
               wlim_in = NW'(1) << cwid_in;
               prev_in = '0;
               pvalid_in = 1'b0;
               first_in = '0;
            end else begin
               if (ext == nfree_ff && pvalid_ff) begin
                  stk_we = 1'b1;
                  stk_wd = first_ff;
                  sdep_in = sdep_ff + 1'b1;
                  cur_in = prev_ff;
               end else if (ext >= nfree_ff) bad = 1'b1;
               if (bad) fin_in = FIN_ERROR;
               else state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (NW'(cur_ff) >= clr + NW'(2) && 32'(sdep_ff) < TS) begin
               state_in = S_WALK_RD;
            end else begin
               if (32'(sdep_ff) < TS) begin
                  stk_we = 1'b1;
                  stk_wd = cur_ff[7:0];
                  sdep_in = sdep_ff + 1'b1;
               end
               if (nfree_ff < wlim_ff && pvalid_ff) begin
                  tab_we = 1'b1;
                  nfree_in = nfree_ff + 1'b1;
               end
               first_in = cur_ff[7:0];
               prev_in = code_ff;
               pvalid_in = 1'b1;
               if (nfree_in >= wlim_ff && 32'(cwid_ff) < MAX_CODE_BITS) begin
                  wlim_in = wlim_ff << 1;
                  cwid_in = cwid_ff + 4'd1;
               end
               state_in = S_DECIDE;
            end
         end
         S_WALK_RD: begin
            stk_we = 1'b1;
            stk_wd = suffix_rd_ff;
            sdep_in = sdep_ff + 1'b1;
            cur_in = prefix_rd_ff;
            state_in = S_WALK;
         end
         S_POP: begin
            stk_ra = sdep_ff[CW-1:0];
            strobe_in = 1'b1;
            status_in = ST_PIXEL;
            pixel_in = stack_rd_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_DECIDE && sdep_ff != '0) stk_ra = sdep_ff[CW-1:0] - 1'b1;
      if (state_ff == S_POP) pixel_in = stack_rd_ff;
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= FIFO_DEPTH) else $error("fifo fill overflow");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cwid_ff) <= MAX_CODE_BITS) else $error("code width overflow");
   a_pop_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |=> rsp_strobe && rsp_status == ST_PIXEL)
      else $error("pop without pixel");
`endif

endmodule

>>> tb/gif_lzw_decoder_core_tb.sv
`timescale 1ns / 100ps

module gif_lzw_decoder_core_tb
   import gld_pkg::*;
();

   localparam int CODE_BITS  = 12;
   localparam int FIFO_SLOTS = 16;
   localparam int DICT_SIZE  = 1 << CODE_BITS;
   localparam int ITEM_GOAL  = 1200;
   localparam int CYCLE_CAP  = 2000000;

   typedef struct {
      status_type status;
      bit [7:0]   pixel;
   } lzw_rsp_type;

   class gif_lzw_scoreboard;
      lzw_rsp_type  pending_rsps[$];
      int           mismatches;
      int           pixels_seen;
      bit [3:0]     size_reg;
      status_type   last_status;
      bit [7:0]     byte_fifo[FIFO_SLOTS];
      int unsigned  fifo_head, fifo_fill;
      int unsigned  reservoir, reservoir_bits, block_left;
      int unsigned  root_bits, code_width, next_code, width_limit;
      int unsigned  prev_code, first_pixel, stack_depth;
      bit           prev_valid;
      finish_type   finish;
      bit [11:0]    prefix_mem[DICT_SIZE];
      bit [7:0]     suffix_mem[DICT_SIZE];
      bit [7:0]     pixel_stack[DICT_SIZE];

      function new();
         size_reg = 4'd8;
         fifo_head = 0;
         fifo_fill = 0;
         restart_decoder();
      endfunction

      function void reload_widths();
         code_width = root_bits + 1;
         next_code = (1 << root_bits) + 2;
         width_limit = 1 << code_width;
         prev_code = 0;
         prev_valid = 0;
         first_pixel = 0;
      endfunction

      function void restart_decoder();
         int unsigned s;
         s = size_reg;
         finish = FIN_RUN;
         if (s < 1 || s > 8 || s >= CODE_BITS) begin
            finish = FIN_ERROR;
            s = 1;
         end
         root_bits = s;
         reservoir = 0;
         reservoir_bits = 0;
         block_left = 0;
         stack_depth = 0;
         reload_widths();
      endfunction

      // 0 code ready, 1 short of bits, 2 zero count byte
      function int fetch_code(output int unsigned code);
         int unsigned b;
         code = 0;
         while (reservoir_bits < code_width) begin
            if (fifo_fill == 0) return 1;
            b = byte_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % FIFO_SLOTS;
            fifo_fill--;
            if (block_left == 0) begin
               if (b == 0) return 2;
               block_left = b;
               continue;
            end
            reservoir = (reservoir | (b << reservoir_bits)) & 24'hFFFFFF;
            reservoir_bits += 8;
            block_left--;
         end
         code = reservoir & ((1 << code_width) - 1);
         reservoir = reservoir >> code_width;
         reservoir_bits -= code_width;
         return 0;
      endfunction

      function void stack_push(int unsigned v);
         if (stack_depth < DICT_SIZE) begin
            pixel_stack[stack_depth] = v[7:0];
            stack_depth++;
         end
      endfunction

      function status_type decode_pixel(output bit [7:0] pix);
         int unsigned c, code, clr;
         int r;
         pix = 0;
         forever begin
            clr = 1 << root_bits;
            if (finish == FIN_END) return ST_END;
            if (finish == FIN_ERROR) return ST_ERROR;
            if (stack_depth > 0) begin
               stack_depth--;
               pix = pixel_stack[stack_depth];
               return ST_PIXEL;
            end
            r = fetch_code(c);
            if (r == 1) return ST_NEED_DATA;
            if (r == 2 || c == clr + 1) begin
               finish = FIN_END;
               continue;
            end
            if (c == clr) begin
               reload_widths();
               continue;
            end
            code = c;
            if (c == next_code && prev_valid) begin
               stack_push(first_pixel);
               code = prev_code;
            end else if (c >= next_code) begin
               finish = FIN_ERROR;
               continue;
            end
            while (code >= clr + 2 && stack_depth < DICT_SIZE) begin
               stack_push(suffix_mem[code % DICT_SIZE]);
               code = prefix_mem[code % DICT_SIZE];
            end
            stack_push(code);
            if (next_code < width_limit && prev_valid) begin
               suffix_mem[next_code % DICT_SIZE] = code[7:0];
               prefix_mem[next_code % DICT_SIZE] = prev_code[11:0];
               next_code++;
            end
            first_pixel = code & 8'hFF;
            prev_code = c % DICT_SIZE;
            prev_valid = 1;
            if (next_code >= width_limit && code_width < CODE_BITS) begin
               width_limit = width_limit << 1;
               code_width++;
            end
         end
      endfunction

      function void note_beat(cmd_type cmd, bit [7:0] data);
         lzw_rsp_type rsp;
         rsp.pixel = 0;
         case (cmd)
            CMD_PUSH: begin
               if (fifo_fill < FIFO_SLOTS) begin
                  byte_fifo[(fifo_head + fifo_fill) % FIFO_SLOTS] = data;
                  fifo_fill++;
                  rsp.status = ST_ACCEPTED;
               end else begin
                  rsp.status = ST_FULL;
               end
               pending_rsps = {pending_rsps, rsp};
            end
            CMD_PULL: begin
               rsp.status = decode_pixel(rsp.pixel);
               last_status = rsp.status;
               pending_rsps = {pending_rsps, rsp};
            end
            CMD_RESTART: restart_decoder();
            default: ;
         endcase
      endfunction

      function void check_beat(status_type status, bit [7:0] pixel);
         lzw_rsp_type exp_rsp;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response status=%0d pixel=%0d", status, pixel);
            return;
         end
         exp_rsp = pending_rsps.pop_front();
         if (exp_rsp.status == ST_PIXEL) pixels_seen++;
         if (status !== exp_rsp.status || pixel !== exp_rsp.pixel) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: status exp %0d got %0d, pixel exp %0d got %0d",
                        exp_rsp.status, status, exp_rsp.pixel, pixel);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_cmd;
   logic [7:0] req_data_byte;
   logic       rsp_strobe;
   logic [2:0] rsp_status;
   logic [7:0] rsp_pixel;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_min_code_size;

   gif_lzw_decoder_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_pixel         (rsp_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_min_code_size (csr_min_code_size)
   );

   gif_lzw_scoreboard sb;
   int  beats;
   int  streams;
   int  cycles;
   bit  burst_mode;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_beat(status_type'(rsp_status), rsp_pixel);
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(cmd_type cmd, bit [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= data;
      do @(posedge clock); while (busy);
      sb.note_beat(cmd, data);
      beats++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_size(bit [3:0] v);
      wait_idle();
      repeat ($urandom_range(0, 5)) @(posedge clock);
      csr_min_code_size <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.size_reg = v;
   endtask

   // restart, then pull out whatever stale bytes remain
   task automatic restart_and_drain();
      send(CMD_RESTART, 8'($urandom));
      while (sb.fifo_fill > 0 && sb.finish == FIN_RUN) begin
         do send(CMD_PULL, 8'($urandom)); while (sb.last_status == ST_PIXEL);
         if (sb.fifo_fill > 0) send(CMD_RESTART, 8'($urandom));
      end
   endtask

   task automatic build_stream(int unsigned sz, output bit [7:0] stream[$]);
      bit [7:0]    data[$];
      int unsigned clr, w, nxt, lim, c, acc, nb, n, rem, blk;
      bit          pv, zero_term;
      int          r;
      clr = 1 << sz;
      w = sz + 1;
      nxt = clr + 2;
      lim = 1 << w;
      pv = 0;
      acc = 0;
      nb = 0;
      stream = {};
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(3, 50);
      zero_term = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3 && i > 0) c = clr;
         else if (!pv) c = $urandom_range(0, clr - 1);
         else if (r < 25 && nxt < (1 << w)) c = nxt;
         else begin
            c = $urandom_range(0, nxt - 1);
            if (c == clr + 1) c = 0;
         end
         acc |= c << nb;
         nb += w;
         while (nb >= 8) begin
            data = {data, acc[7:0]};
            acc >>= 8;
            nb -= 8;
         end
         if (c == clr) begin
            w = sz + 1;
            nxt = clr + 2;
            lim = 1 << w;
            pv = 0;
         end else begin
            if (nxt < lim && pv) nxt++;
            pv = 1;
            if (nxt >= lim && w < CODE_BITS) begin
               lim <<= 1;
               w++;
            end
         end
      end
      if (!zero_term) begin
         acc |= (clr + 1) << nb;
         nb += w;
      end
      while (nb > 0) begin
         data = {data, acc[7:0]};
         acc >>= 8;
         nb = (nb > 8) ? nb - 8 : 0;
      end
      rem = data.size();
      while (rem > 0) begin
         blk = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 30);
         if (blk > rem) blk = rem;
         stream = {stream, blk[7:0]};
         repeat (blk) stream = {stream, data.pop_front()};
         rem -= blk;
      end
      if (zero_term) stream = {stream, 8'd0};
   endtask

   task automatic run_stream(int unsigned sz);
      bit [7:0] stream[$];
      int       idx;
      build_stream(sz, stream);
      idx = 0;
      sb.last_status = ST_PIXEL;
      forever begin
         if (beats >= ITEM_GOAL) begin
            break;
         end else if (idx < stream.size() && sb.fifo_fill < FIFO_SLOTS &&
             ($urandom_range(0, 2) != 0 || sb.stack_depth == 0)) begin
            send(CMD_PUSH, stream[idx]);
            idx++;
         end else if (idx >= stream.size() &&
                      (sb.finish != FIN_RUN || sb.last_status == ST_NEED_DATA)) begin
            break;
         end else begin
            send(CMD_PULL, 8'($urandom));
         end
      end
      streams++;
   endtask

   task automatic run_noise();
      int r;
      repeat ($urandom_range(10, 40)) begin
         r = $urandom_range(0, 9);
         if (r < 6) send(CMD_PUSH, 8'($urandom));
         else if (r < 8) send(CMD_PULL, 8'($urandom));
         else if (r < 9) send(CMD_RESTART, 8'($urandom));
         else send(CMD_NONE, 8'($urandom));
      end
   endtask

   initial begin
      bit [3:0] sizes[6];
      bit [3:0] sz;
      int       phase;
      sizes = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd9};
      sb = new();
      beats = 0;
      streams = 0;
      burst_mode = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_PUSH;
      req_data_byte = 8'd0;
      csr_valid = 1'b0;
      csr_min_code_size = 4'd8;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(CMD_PULL, 8'h00);
      send(CMD_NONE, 8'hFF);
      send(CMD_PUSH, 8'h00);
      send(CMD_PULL, 8'hFF);
      send(CMD_PULL, 8'h00);
      send(CMD_RESTART, 8'h00);
      send(CMD_PUSH, 8'h01);
      send(CMD_PUSH, 8'hFF);
      send(CMD_PULL, 8'h00);
      send(CMD_PUSH, 8'h01);
      send(CMD_PUSH, 8'hFF);
      send(CMD_PULL, 8'h00);
      send(CMD_PULL, 8'h00);
      repeat (17) send(CMD_PUSH, 8'($urandom));

      phase = 0;
      while (beats < ITEM_GOAL) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         if (phase < 6) write_size(sizes[phase]);
         else if ($urandom_range(0, 2) == 0) begin
            sz = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0) sz = 4'd0;
            write_size(sz);
         end
         restart_and_drain();
         if (sb.finish == FIN_RUN && sb.fifo_fill == 0 && $urandom_range(0, 4) != 0)
            run_stream(sb.root_bits);
         else
            run_noise();
         phase++;
      end

      start <= 1'b0;
      while (sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Ran %0d beats: %0d well-formed streams, %0d pixels, noise and restarts",
               beats, streams, sb.pixels_seen);
      $display("Mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_rsps.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
